// ===== rtl/core/bls_pkg.sv =====
// shared types, codes and constants of the battery load shedding sequencer
`timescale 1ns / 1ps
`default_nettype none

package bls_pkg;

	// module table: sixteen slots, the sweeps visit the first NUM_MODULES
	localparam int SLOTS = 16;
	localparam int SLOT_W = 4;

	// field widths
	localparam int MV_W = 13;
	localparam int HYS_W = 10;
	localparam int SUM_W = 14;
	localparam int ENABLES_W = 8;
	localparam int HS_W = 2;
	localparam int SLEEP_W = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 13;

	// parameter defaults
	localparam int NUM_MODULES_DEF = 8;
	localparam int MAINBOARD_INDEX_DEF = 0;
	localparam int BUZZER_INDEX_DEF = 1;
	localparam int COMPUTER_INDEX_DEF = 2;

	// register reset values
	localparam logic [MV_W-1:0] EMPTY_TH_RST = 13'd3300;
	localparam logic [MV_W-1:0] ALL_OFF_TH_RST = 13'd3500;
	localparam logic [MV_W-1:0] SYSTEMS_TH_RST = 13'd3600;
	localparam logic [MV_W-1:0] ALARM_TH_RST = 13'd3700;
	localparam logic [HYS_W-1:0] ALARM_HYS_RST = 10'd100;
	localparam logic [HYS_W-1:0] RESTORE_HYS_RST = 10'd200;
	localparam logic [ENABLES_W-1:0] AUTO_ON_RST = 8'd0;

	// main computer handshake codes
	localparam logic [HS_W-1:0] HS_SHUTDOWN_DONE = 2'd1;
	localparam logic [HS_W-1:0] HS_SYSTEM_UP = 2'd2;

	// sleep request codes
	localparam logic [SLEEP_W-1:0] SLEEP_NONE = 2'd0;
	localparam logic [SLEEP_W-1:0] SLEEP_NORMAL = 2'd1;
	localparam logic [SLEEP_W-1:0] SLEEP_LOW_BATT = 2'd2;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_EMPTY_TH = 3'd0,
		CFG_ALL_OFF_TH = 3'd1,
		CFG_SYSTEMS_TH = 3'd2,
		CFG_ALARM_TH = 3'd3,
		CFG_ALARM_HYS = 3'd4,
		CFG_RESTORE_HYS = 3'd5,
		CFG_AUTO_ON = 3'd6
	} cfg_reg_t;

	// module status
	typedef enum logic [1:0] {
		MS_OFF = 2'd0,
		MS_ON = 2'd1,
		MS_GOING_ON = 2'd2,
		MS_GOING_OFF = 2'd3
	} mod_state_t;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ALARM,
		ST_SWEEP_A,
		ST_MAIN_ON,
		ST_ROVER,
		ST_BUTTON,
		ST_SWEEP_B,
		ST_FINISH,
		ST_DONE
	} ctrl_state_t;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_ALARM,
		OP_SWEEP_A,
		OP_MAIN_ON,
		OP_ROVER,
		OP_BUTTON,
		OP_SWEEP_B,
		OP_FINISH,
		OP_PUBLISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic [SLOT_W-1:0] idx;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/bls_ctrl.sv =====
// controller state machine that sequences the parts of one tick
`timescale 1ns / 1ps
`default_nettype none

module bls_ctrl import bls_pkg::*; #(
	parameter int NUM_MODULES = NUM_MODULES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire dp_status_t status,
	output dp_cmd_t cmd
);

	localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_MODULES - 1);

	ctrl_state_t state_q, state_d;
	logic [SLOT_W-1:0] idx_q;
	logic in_sweep;
	logic idx_last;

	assign in_sweep = (state_q == ST_SWEEP_A) || (state_q == ST_SWEEP_B);
	assign idx_last = (idx_q == LAST_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			idx_q <= (in_sweep && !idx_last) ? idx_q + 1'b1 : '0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_ALARM;
			ST_ALARM: state_d = ST_SWEEP_A;
			ST_SWEEP_A: if (idx_last) state_d = ST_MAIN_ON;
			ST_MAIN_ON: state_d = ST_ROVER;
			ST_ROVER: state_d = ST_BUTTON;
			ST_BUTTON: state_d = ST_SWEEP_B;
			ST_SWEEP_B: if (idx_last) state_d = ST_FINISH;
			ST_FINISH: state_d = ST_DONE;
			ST_DONE: if (status.out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		cmd.idx = idx_q;
		cmd.op = OP_NONE;
		unique case (state_q)
			ST_IDLE: cmd.op = in_valid ? OP_LOAD : OP_NONE;
			ST_ALARM: cmd.op = OP_ALARM;
			ST_SWEEP_A: cmd.op = OP_SWEEP_A;
			ST_MAIN_ON: cmd.op = OP_MAIN_ON;
			ST_ROVER: cmd.op = OP_ROVER;
			ST_BUTTON: cmd.op = OP_BUTTON;
			ST_SWEEP_B: cmd.op = OP_SWEEP_B;
			ST_FINISH: cmd.op = OP_FINISH;
			ST_DONE: cmd.op = status.out_free ? OP_PUBLISH : OP_NONE;
			default: cmd.op = OP_NONE;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/bls_datapath.sv =====
// datapath: registers, module table, threshold compares and result register
`timescale 1ns / 1ps
`default_nettype none

module bls_datapath import bls_pkg::*; #(
	parameter int NUM_MODULES = NUM_MODULES_DEF,
	parameter int MAINBOARD_INDEX = MAINBOARD_INDEX_DEF,
	parameter int BUZZER_INDEX = BUZZER_INDEX_DEF,
	parameter int COMPUTER_INDEX = COMPUTER_INDEX_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire dp_cmd_t cmd,
	output dp_status_t status,
	input wire logic cfg_write_en,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data,
	input wire logic [MV_W-1:0] battery_mv,
	input wire logic button_pressed,
	input wire logic button_pressed_again,
	input wire logic switch_on_position,
	input wire logic woke_from_comparator,
	input wire logic [HS_W-1:0] computer_handshake,
	output logic out_valid,
	input wire logic out_stall,
	output logic [ENABLES_W-1:0] module_enables,
	output logic current_sense_on,
	output logic [SLEEP_W-1:0] sleep_request,
	output logic system_enabled
);

	localparam logic [SLOT_W-1:0] MB = SLOT_W'(MAINBOARD_INDEX);
	localparam logic [SLOT_W-1:0] BZ = SLOT_W'(BUZZER_INDEX);
	localparam logic [SLOT_W-1:0] CP = SLOT_W'(COMPUTER_INDEX);

	// configuration
	logic [MV_W-1:0] empty_th_q, all_off_th_q, systems_th_q, alarm_th_q;
	logic [HYS_W-1:0] alarm_hys_q, restore_hys_q;
	logic [ENABLES_W-1:0] auto_on_q;

	// captured tick inputs
	logic [MV_W-1:0] battery_q;
	logic b1_q, b2_q, sw_q, wake_q;
	logic [HS_W-1:0] hs_q;

	// tick state
	mod_state_t ms_q [SLOTS];
	mod_state_t ms_d [SLOTS];
	logic [SLOTS-1:0] le_q, le_d;
	logic sys_on_q, sys_on_d;
	logic alarm_q, alarm_d;
	logic btn_now_q, btn_now_d;
	logic btn_before_q, btn_before_d;
	logic sense_q, sense_d;
	logic [SLEEP_W-1:0] sleep_q, sleep_d;
	logic shed_q, shed_d;
	logic any_q, any_d;

	// result register
	logic out_valid_q;
	logic [ENABLES_W-1:0] enables_out_q;
	logic sense_out_q;
	logic [SLEEP_W-1:0] sleep_out_q;
	logic sys_on_out_q;
	logic [ENABLES_W-1:0] enables_now;

	// compares
	logic [SUM_W-1:0] v_ext;
	logic [SUM_W-1:0] ao_ahys, alarm_ahys, ao_rh, sys_rh;
	logic v_lt_empty, v_lt_ao, v_lt_sys, v_lt_alarm;
	logic v_gt_ao_ahys, v_gt_alarm_ahys, v_gt_ao_rh, v_gt_sys_rh;

	// sweep element and start-up request
	mod_state_t s_cur, s_mid;
	logic l_mid;
	logic idx_is_mb, idx_is_bz, idx_is_cp;
	logic rover_go;

	assign v_ext = SUM_W'(battery_q);
	assign ao_ahys = SUM_W'(all_off_th_q) + SUM_W'(alarm_hys_q);
	assign alarm_ahys = SUM_W'(alarm_th_q) + SUM_W'(alarm_hys_q);
	assign ao_rh = SUM_W'(all_off_th_q) + SUM_W'(restore_hys_q);
	assign sys_rh = SUM_W'(systems_th_q) + SUM_W'(restore_hys_q);

	assign v_lt_empty = battery_q < empty_th_q;
	assign v_lt_ao = battery_q < all_off_th_q;
	assign v_lt_sys = battery_q < systems_th_q;
	assign v_lt_alarm = battery_q < alarm_th_q;
	assign v_gt_ao_ahys = v_ext > ao_ahys;
	assign v_gt_alarm_ahys = v_ext > alarm_ahys;
	assign v_gt_ao_rh = v_ext > ao_rh;
	assign v_gt_sys_rh = v_ext > sys_rh;

	assign idx_is_mb = (cmd.idx == MB);
	assign idx_is_bz = (cmd.idx == BZ);
	assign idx_is_cp = (cmd.idx == CP);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_th_q <= EMPTY_TH_RST;
			all_off_th_q <= ALL_OFF_TH_RST;
			systems_th_q <= SYSTEMS_TH_RST;
			alarm_th_q <= ALARM_TH_RST;
			alarm_hys_q <= ALARM_HYS_RST;
			restore_hys_q <= RESTORE_HYS_RST;
			auto_on_q <= AUTO_ON_RST;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				CFG_EMPTY_TH: empty_th_q <= cfg_data;
				CFG_ALL_OFF_TH: all_off_th_q <= cfg_data;
				CFG_SYSTEMS_TH: systems_th_q <= cfg_data;
				CFG_ALARM_TH: alarm_th_q <= cfg_data;
				CFG_ALARM_HYS: alarm_hys_q <= cfg_data[HYS_W-1:0];
				CFG_RESTORE_HYS: restore_hys_q <= cfg_data[HYS_W-1:0];
				CFG_AUTO_ON: auto_on_q <= cfg_data[ENABLES_W-1:0];
				default: ;
			endcase
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			battery_q <= battery_mv;
			b1_q <= button_pressed;
			b2_q <= button_pressed_again;
			sw_q <= switch_on_position;
			wake_q <= woke_from_comparator;
			hs_q <= computer_handshake;
		end
	end

	// next tick state
	always_comb begin
		ms_d = ms_q;
		le_d = le_q;
		sys_on_d = sys_on_q;
		alarm_d = alarm_q;
		btn_now_d = btn_now_q;
		btn_before_d = btn_before_q;
		sense_d = sense_q;
		sleep_d = sleep_q;
		shed_d = shed_q;
		any_d = any_q;
		rover_go = 1'b0;
		s_cur = ms_q[cmd.idx];
		s_mid = s_cur;
		l_mid = le_q[cmd.idx];

		unique case (cmd.op)
			OP_NONE, OP_LOAD, OP_PUBLISH: ;
			OP_ALARM: begin
				if (v_lt_alarm && v_gt_ao_ahys && sys_on_q)
					alarm_d = 1'b1;
				else if (v_gt_alarm_ahys || v_lt_ao)
					alarm_d = 1'b0;
				// buzzer toggles each tick while the alarm runs
				if (alarm_d && ms_q[BZ] == MS_OFF) begin
					le_d[BZ] = 1'b1;
					ms_d[BZ] = MS_ON;
				end else begin
					le_d[BZ] = 1'b0;
					ms_d[BZ] = MS_OFF;
				end
				sleep_d = v_lt_empty ? SLEEP_LOW_BATT : SLEEP_NONE;
				// either shedding level drops the current sense supply
				if (v_lt_empty || v_lt_ao) sense_d = 1'b0;
				shed_d = 1'b0;
				any_d = 1'b0;
			end
			OP_SWEEP_A: begin
				// pending transition first
				unique case (s_cur)
					MS_GOING_OFF: begin
						if (!idx_is_cp || hs_q == HS_SHUTDOWN_DONE) begin
							l_mid = 1'b0;
							s_mid = MS_OFF;
						end
					end
					MS_GOING_ON: begin
						l_mid = 1'b1;
						if (!idx_is_cp || hs_q == HS_SYSTEM_UP) s_mid = MS_ON;
					end
					MS_OFF, MS_ON: ;
				endcase
				// then shedding level
				priority if (v_lt_empty) begin
					l_mid = 1'b0;
					s_mid = MS_OFF;
				end else if (v_lt_ao) begin
					if (s_mid == MS_ON) s_mid = MS_GOING_OFF;
				end else if (v_lt_sys) begin
					if (!idx_is_mb && !idx_is_bz && s_mid == MS_ON) s_mid = MS_GOING_OFF;
				end else begin
				end
				ms_d[cmd.idx] = s_mid;
				le_d[cmd.idx] = l_mid;
			end
			OP_MAIN_ON: begin
				if (ms_q[MB] == MS_OFF && sys_on_q && v_gt_ao_rh) begin
					sys_on_d = 1'b1;
					sense_d = 1'b1;
					le_d[MB] = 1'b1;
					ms_d[MB] = MS_ON;
				end
			end
			OP_ROVER: begin
				rover_go = (ms_q[CP] == MS_OFF) && sys_on_q && v_gt_sys_rh;
			end
			OP_BUTTON: begin
				btn_before_d = btn_now_q;
				if (b1_q) begin
					btn_now_d = 1'b1;
					if (!btn_now_q || wake_q) begin
						if (b2_q) rover_go = 1'b1;
						else btn_now_d = 1'b0;
					end
				end else begin
					btn_now_d = 1'b0;
					if (btn_now_q) begin
						if (!b2_q) begin
							// switch off: soft shed runs in the next sweep
							sys_on_d = 1'b0;
							shed_d = 1'b1;
							sense_d = 1'b0;
						end else begin
							btn_now_d = 1'b1;
						end
					end
				end
			end
			OP_SWEEP_B: begin
				if (shed_q && s_cur == MS_ON) ms_d[cmd.idx] = MS_GOING_OFF;
				any_d = any_q | (s_cur != MS_OFF);
			end
			OP_FINISH: begin
				if (sys_on_q && ms_q[CP] == MS_OFF && v_gt_sys_rh)
					ms_d[CP] = MS_GOING_ON;
				else if (!sys_on_q && ms_q[CP] == MS_ON)
					ms_d[CP] = MS_GOING_OFF;
				if (!sys_on_q && !sw_q && !any_q && sleep_q == SLEEP_NONE)
					sleep_d = SLEEP_NORMAL;
			end
			default: ;
		endcase

		// rover start-up, later writes win where slots coincide
		if (rover_go) begin
			if (sw_q && v_gt_ao_rh) begin
				btn_now_d = 1'b1;
				btn_before_d = 1'b1;
				sys_on_d = 1'b1;
				sense_d = 1'b1;
				le_d[MB] = 1'b1;
				ms_d[MB] = MS_ON;
			end
			if (sw_q && v_gt_sys_rh) begin
				for (int i = 0; i < ENABLES_W; i++) begin
					if (i < NUM_MODULES && auto_on_q[i]) begin
						le_d[i] = 1'b1;
						ms_d[i] = MS_ON;
					end
				end
				le_d[CP] = 1'b1;
				ms_d[CP] = MS_GOING_ON;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) ms_q[i] <= MS_OFF;
			le_q <= '0;
			sys_on_q <= 1'b0;
			alarm_q <= 1'b0;
			btn_now_q <= 1'b0;
			btn_before_q <= 1'b0;
			sense_q <= 1'b0;
			sleep_q <= SLEEP_NONE;
			shed_q <= 1'b0;
			any_q <= 1'b0;
		end else begin
			ms_q <= ms_d;
			le_q <= le_d;
			sys_on_q <= sys_on_d;
			alarm_q <= alarm_d;
			btn_now_q <= btn_now_d;
			btn_before_q <= btn_before_d;
			sense_q <= sense_d;
			sleep_q <= sleep_d;
			shed_q <= shed_d;
			any_q <= any_d;
		end
	end

	// visible enables
	always_comb begin
		enables_now = '0;
		for (int i = 0; i < ENABLES_W; i++)
			enables_now[i] = (i < NUM_MODULES) && le_q[i];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_PUBLISH) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_PUBLISH) begin
			enables_out_q <= enables_now;
			sense_out_q <= sense_q;
			sleep_out_q <= sleep_q;
			sys_on_out_q <= sys_on_q;
		end
	end

	assign status.out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign module_enables = enables_out_q;
	assign current_sense_on = sense_out_q;
	assign sleep_request = sleep_out_q;
	assign system_enabled = sys_on_out_q;

endmodule

`default_nettype wire

// ===== rtl/core/battery_load_shedding_sequencer_core.sv =====
// top level of the battery load shedding sequencer
`timescale 1ns / 1ps
`default_nettype none

// one input transfer is one control tick: battery voltage, two button samples,
// switch position, wakeup source and the main computer handshake. the tick runs
// as a fixed sequence: buzzer alarm, a sweep over the module table that
// completes pending transitions and applies load shedding, mainboard restore,
// rover start-up and button handling, a second sweep for switch-off shedding and
// the any-module-running check, the computer fix-up and sleep decision, and the
// load of the result register, which waits while a held result is still stalled.
// the next input transfer is taken the cycle after the result register loads,
// so a new tick is not taken before the last one is through. the result
// register keeps a finished result while the next tick is taken in; in_stall is
// high for the whole tick. configuration writes land at once and are meant for
// idle periods between ticks; register indexes above the list are ignored.
module battery_load_shedding_sequencer_core import bls_pkg::*; #(
	parameter int NUM_MODULES = NUM_MODULES_DEF,
	parameter int MAINBOARD_INDEX = MAINBOARD_INDEX_DEF,
	parameter int BUZZER_INDEX = BUZZER_INDEX_DEF,
	parameter int COMPUTER_INDEX = COMPUTER_INDEX_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	// configuration write port
	input wire logic cfg_write_en,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data,
	// tick input channel
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [MV_W-1:0] battery_mv,
	input wire logic button_pressed,
	input wire logic button_pressed_again,
	input wire logic switch_on_position,
	input wire logic woke_from_comparator,
	input wire logic [HS_W-1:0] computer_handshake,
	// result channel
	output logic out_valid,
	input wire logic out_stall,
	output logic [ENABLES_W-1:0] module_enables,
	output logic current_sense_on,
	output logic [SLEEP_W-1:0] sleep_request,
	output logic system_enabled
);

	dp_cmd_t cmd;
	dp_status_t status;

	// sequencer: walks the parts of the tick and the table sweeps
	bls_ctrl #(
		.NUM_MODULES(NUM_MODULES)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.status(status),
		.cmd(cmd)
	);

	// registers, module table, compares and result register
	bls_datapath #(
		.NUM_MODULES(NUM_MODULES),
		.MAINBOARD_INDEX(MAINBOARD_INDEX),
		.BUZZER_INDEX(BUZZER_INDEX),
		.COMPUTER_INDEX(COMPUTER_INDEX)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.battery_mv(battery_mv),
		.button_pressed(button_pressed),
		.button_pressed_again(button_pressed_again),
		.switch_on_position(switch_on_position),
		.woke_from_comparator(woke_from_comparator),
		.computer_handshake(computer_handshake),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.module_enables(module_enables),
		.current_sense_on(current_sense_on),
		.sleep_request(sleep_request),
		.system_enabled(system_enabled)
	);

	// a taken tick keeps the input side closed on the next cycle
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input side open right after a tick transfer");

	// a result only appears at the end of a tick in progress
	a_result_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result offered without a tick in progress");

	// normal deep sleep is only asked for with the system switched off
	a_sleep_needs_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sleep_request == SLEEP_NORMAL |-> !system_enabled)
		else $error("normal sleep requested while system is on");

endmodule

`default_nettype wire
